>>> rtl/core/sm4_pkg.sv
package sm4_pkg;

  // Cipher geometry
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned RK_AW     = $clog2(ROUNDS);
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1
  } sm4_cfg_idx_e;

  // System parameter FK
  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_EXP,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } sm4_state_e;

  // Request payloads
  typedef struct packed {
    logic        func;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_out_t;

  // Shared round unit operand
  typedef struct packed {
    logic        key_mode;
    logic [31:0] word;
  } sm4_rnd_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution
  function automatic logic [31:0] tau(input logic [31:0] v);
    tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // CK word: byte j of word i is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] idx);
    logic [7:0]  pos;
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      pos = {1'b0, idx, 2'(j)};
      w[31-8*j -: 8] = pos * 8'd7;
    end
    ck_word = w;
  endfunction

endpackage

>>> rtl/core/sm4_round.sv
module sm4_round
  import sm4_pkg::*;
(
  input  sm4_rnd_req_t rnd_i,
  output logic [31:0]  t_o
);

  logic [31:0] sub;

  // Nonlinear layer
  assign sub = tau(rnd_i.word);

  // Linear layer: L' for the key schedule, L for data rounds
  always_comb begin
    if (rnd_i.key_mode) begin
      t_o = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
    end else begin
      t_o = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
          ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
    end
  end

endmodule

>>> rtl/core/sm4_rk_mem.sv
module sm4_rk_mem
  import sm4_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [RK_AW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [RK_AW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [ROUNDS];
  logic [31:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sm4_block_cipher_top.sv
// SM4 block cipher, one 128-bit block per request.
// Configuration: write key_high (index 0) and key_low (index 1) on the cfg
// channel while the core is idle; cfg_ready_o is always high. Any key write
// marks the round keys stale.
// Input: a request is taken when in_valid_i is high and in_stall_o is low.
// in_stall_o is high from acceptance until the result is parked in the
// output register, so one block is in flight at a time.
// Processing: 32 rounds on the shared round unit, one per cycle, then an
// output step that parks the result in the output register. When the
// round keys are stale, key expansion runs first on the same unit: 32
// schedule rounds, then one round key memory read.
// Output: out_valid_o holds with a stable payload until out_stall_i is low.
// While the result waits, the next block may be accepted; it finishes its
// rounds and waits in the core until the output register frees up.
// Reset: keys clear to zero, round keys are marked stale, no result valid.
module sm4_block_cipher_top
  import sm4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sm4_in_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sm4_out_t             out_req_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  localparam logic [RK_AW-1:0] LAST = RK_AW'(ROUNDS - 1);

  sm4_state_e       state_q, state_d;
  logic [RK_AW-1:0] cnt_q, cnt_d;
  logic             keys_ready_q, keys_ready_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      key_high_q, key_low_q;
  logic             dec_q, dec_d;
  logic [127:0]     x_q, x_d;
  logic [127:0]     k_q, k_d;
  sm4_out_t         out_q, out_d;

  sm4_rnd_req_t     rnd;
  logic [31:0]      t;
  logic [31:0]      rk;
  logic             rk_we;
  logic [RK_AW-1:0] rk_raddr;
  logic             cfg_wr;

  // Round key index, reversed for decryption
  function automatic logic [RK_AW-1:0] rk_index(input logic dec, input logic [RK_AW-1:0] i);
    rk_index = dec ? (LAST - i) : i;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_i)
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Shared round unit operand: key schedule or data round
  always_comb begin
    rnd.key_mode = (state_q == ST_KEY_EXP);
    if (rnd.key_mode) begin
      rnd.word = k_q[95:64] ^ k_q[63:32] ^ k_q[31:0] ^ ck_word(cnt_q);
    end else begin
      rnd.word = x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk;
    end
  end

  sm4_round u_round (
    .rnd_i (rnd),
    .t_o   (t)
  );

  sm4_rk_mem u_rk_mem (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (cnt_q),
    .wdata_i (k_q[127:96] ^ t),
    .raddr_i (rk_raddr),
    .rdata_o (rk)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    out_valid_d  = out_valid_q && out_stall_i;
    dec_d        = dec_q;
    x_d          = x_q;
    k_d          = k_q;
    out_d        = out_q;
    rk_we        = 1'b0;
    rk_raddr     = rk_index(dec_q, '0);

    case (state_q)
      ST_IDLE: begin
        rk_raddr = rk_index(in_req_i.func, '0);
        if (in_valid_i) begin
          dec_d = in_req_i.func;
          x_d   = {in_req_i.block_high, in_req_i.block_low};
          cnt_d = '0;
          if (keys_ready_q) begin
            state_d = ST_RUN;
          end else begin
            k_d     = {key_high_q, key_low_q} ^ {FK0, FK1, FK2, FK3};
            state_d = ST_KEY_EXP;
          end
        end
      end
      ST_KEY_EXP: begin
        rk_we = 1'b1;
        k_d   = {k_q[95:0], k_q[127:96] ^ t};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          keys_ready_d = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        // prefetch the key for the next round
        rk_raddr = rk_index(dec_q, cnt_q + 1'b1);
        x_d      = {x_q[95:0], x_q[127:96] ^ t};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = {x_q[31:0], x_q[63:32], x_q[95:64], x_q[127:96]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // key writes make the round keys stale
    if (cfg_wr && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW)) begin
      keys_ready_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
    x_q   <= x_d;
    k_q   <= k_d;
    out_q <= out_d;
  end

endmodule

>>> tb/sm4_result_monitor.sv
module sm4_result_monitor
  import sm4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  sm4_in_t              in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  sm4_out_t             out_req_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  // Shadow of the key registers and the expanded schedule
  logic [63:0] key_high_q;
  logic [63:0] key_low_q;
  logic [31:0] rk_q [ROUNDS];
  logic        rk_stale_q;

  // Cipher outputs owed by the block, oldest first
  sm4_out_t    expected_blocks [$];
  sm4_out_t    want;
  int unsigned err_cnt;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] v);
    logic [31:0] w;
    for (int b = 0; b < 4; b++) w[8*b +: 8] = SBOX[v[8*b +: 8]];
    return w;
  endfunction

  // Round transform for data: substitution, then the five-term diffusion
  function automatic logic [31:0] data_mix(input logic [31:0] v);
    logic [31:0] s;
    s = sbox_word(v);
    return s ^ rol32(s, 2) ^ rol32(s, 10) ^ rol32(s, 18) ^ rol32(s, 24);
  endfunction

  // Round transform for the key schedule: lighter diffusion
  function automatic logic [31:0] key_mix(input logic [31:0] v);
    logic [31:0] s;
    s = sbox_word(v);
    return s ^ rol32(s, 13) ^ rol32(s, 23);
  endfunction

  // CK: byte j of word i is (4i + j) * 7, low 8 bits, MSB first
  function automatic logic [31:0] ck_const(input int unsigned i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) w = {w[23:0], 8'((4 * i + j) * 7)};
    return w;
  endfunction

  task automatic refresh_round_keys();
    logic [31:0] k [4];
    logic [31:0] nk;
    k[0] = key_high_q[63:32] ^ FK0;
    k[1] = key_high_q[31:0]  ^ FK1;
    k[2] = key_low_q[63:32]  ^ FK2;
    k[3] = key_low_q[31:0]   ^ FK3;
    for (int r = 0; r < ROUNDS; r++) begin
      nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck_const(r));
      rk_q[r] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
    rk_stale_q = 1'b0;
  endtask

  // 32 rounds; decrypt walks the schedule backward; output word-reversed
  function automatic sm4_out_t sm4_cipher(input sm4_in_t req);
    logic [31:0] x [4];
    logic [31:0] rk;
    logic [31:0] nx;
    sm4_out_t    res;
    x[0] = req.block_high[63:32];
    x[1] = req.block_high[31:0];
    x[2] = req.block_low[63:32];
    x[3] = req.block_low[31:0];
    for (int r = 0; r < ROUNDS; r++) begin
      rk = req.func ? rk_q[ROUNDS - 1 - r] : rk_q[r];
      nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ rk);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    res.result_high = {x[3], x[2]};
    res.result_low  = {x[1], x[0]};
    return res;
  endfunction

  // Watch all three channels; results are checked before new requests are queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q = '0;
      key_low_q  = '0;
      rk_stale_q = 1'b1;
      err_cnt    = 0;
      expected_blocks.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_req_i);
          err_cnt++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_req_i.result_high !== want.result_high) begin
            $display("%0t: result_high expected %h got %h",
                     $time, want.result_high, out_req_i.result_high);
            err_cnt++;
          end
          if (out_req_i.result_low !== want.result_low) begin
            $display("%0t: result_low expected %h got %h",
                     $time, want.result_low, out_req_i.result_low);
            err_cnt++;
          end
        end
      end

      // Any key write invalidates the schedule; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          CFG_KEY_HIGH: begin
            key_high_q = cfg_data_i;
            rk_stale_q = 1'b1;
          end
          CFG_KEY_LOW: begin
            key_low_q  = cfg_data_i;
            rk_stale_q = 1'b1;
          end
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (rk_stale_q) refresh_round_keys();
        expected_blocks.push_back(sm4_cipher(in_req_i));
      end

      pending_o <= expected_blocks.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

>>> tb/sm4_block_cipher_top_test.sv
module sm4_block_cipher_top_test;
  import sm4_pkg::*;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 128;
  localparam int unsigned TAIL_CYCLES = 80;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  sm4_in_t              in_req_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  sm4_out_t             out_req_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [63:0]          cfg_data_i;

  int unsigned pending_cnt;
  int unsigned error_cnt;

  // Idle bursts per side; long holds are asked by the sender, served by the sink
  int unsigned tx_left = 0;
  bit          tx_quiet = 1'b0;
  int unsigned rx_left = 0;
  bit          rx_quiet = 1'b0;
  int unsigned long_holds_asked = 0;
  int unsigned long_holds_done = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sm4_block_cipher_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  sm4_result_monitor u_result_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_i   (out_req_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending_cnt),
    .errors_o    (error_cnt)
  );

  // Gap before the next item; each burst is busy or gap-free, picked at random
  function automatic int unsigned pick_gap(inout int unsigned left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(1, 40);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Mostly random, sometimes all-zero, all-one or a single set bit
  function automatic logic [63:0] rand_data();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Leaves in_valid_i high; the caller lowers it after the last request
  task automatic send_block(input logic func, input logic [63:0] hi, input logic [63:0] lo);
    int unsigned gap;
    sm4_in_t     req;
    gap            = pick_gap(tx_left, tx_quiet);
    req.func       = func;
    req.block_high = hi;
    req.block_low  = lo;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic random_phase(input int unsigned n_items, input bit with_hold);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) long_holds_asked++;
      send_block($urandom_range(0, 1) ? FUNC_DEC : FUNC_ENC, rand_data(), rand_data());
    end
    drain();
  endtask

  // Result sink: random stalls, gap-free stretches and the occasional long hold
  initial begin : result_sink
    int unsigned gap;
    forever begin
      if (long_holds_done != long_holds_asked) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_holds_done++;
      end else begin
        gap = pick_gap(rx_left, rx_quiet);
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Request source and verdict
  initial begin : stimulus
    logic [63:0] kh;
    logic [63:0] kl;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_idx_i   <= CFG_KEY_HIGH;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key (all zero), no write yet
    send_block(FUNC_ENC, '0, '0);
    send_block(FUNC_DEC, '0, '0);
    send_block(FUNC_ENC, '1, '1);
    send_block(FUNC_DEC, '1, '1);
    drain();

    // Standard example key, round trip of the example block
    write_reg(CFG_KEY_HIGH, 64'h0123456789abcdef);
    write_reg(CFG_KEY_LOW,  64'hfedcba9876543210);
    cfg_valid_i <= 1'b0;
    send_block(FUNC_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(FUNC_DEC, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
    send_block(FUNC_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(FUNC_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();

    // All-ones key
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW,  '1);
    cfg_valid_i <= 1'b0;
    send_block(FUNC_ENC, '0, '0);
    send_block(FUNC_DEC, '0, '0);
    send_block(FUNC_ENC, '1, '1);
    send_block(FUNC_DEC, '1, '1);
    drain();

    // Writes to unused indexes must leave the key alone
    write_reg(CFG_SPARE_A, rand_data());
    write_reg(CFG_SPARE_B, rand_data());
    cfg_valid_i <= 1'b0;
    send_block(FUNC_ENC, 64'h8000000000000001, 64'h0000000000000001);
    send_block(FUNC_DEC, 64'h8000000000000000, 64'h8000000000000000);
    drain();

    // Change only the low half of the key
    write_reg(CFG_KEY_LOW, '0);
    cfg_valid_i <= 1'b0;
    send_block(FUNC_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(FUNC_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();

    // Random phases, a new key setting for each
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      kh = (p == 0) ? '0 : (p == 1) ? '1 : rand_data();
      kl = (p == 0) ? '0 : (p == 1) ? '1 : rand_data();
      case ($urandom_range(0, 3))
        0: write_reg(CFG_KEY_HIGH, kh);
        1: write_reg(CFG_KEY_LOW, kl);
        default: begin
          write_reg(CFG_KEY_LOW, kl);
          write_reg(CFG_KEY_HIGH, kh);
        end
      endcase
      if ($urandom_range(0, 3) == 0) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                               rand_data());
      cfg_valid_i <= 1'b0;
      random_phase(PHASE_ITEMS, (p == 3) || (p == 8));
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
rtl/core/sm4_pkg.sv
rtl/core/sm4_round.sv
rtl/core/sm4_rk_mem.sv
rtl/core/sm4_block_cipher_top.sv
tb/sm4_result_monitor.sv
tb/sm4_block_cipher_top_test.sv
